@@ rtl/assert_macros.svh @@
// assertion helpers, clocked on clock and held off during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_CLK(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("assertion failed");

`define ASSERT_NEVER(lbl, expr) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(expr)) \
      else $error("forbidden condition seen");

`else

`define ASSERT_CLK(lbl, prop)

`define ASSERT_NEVER(lbl, expr)

`endif

`endif

@@ rtl/u8hk_pkg.sv @@
package u8hk_pkg;

   localparam int FIELD_LEN = 20;
   localparam int POS_W     = 5;
   localparam int CP_W      = 21;

   localparam logic [CP_W-1:0] KANA_FIRST  = 21'h030A1;
   localparam logic [CP_W-1:0] KANA_LAST   = 21'h030FC;
   localparam logic [CP_W-1:0] PRINT_LOW   = 21'h00020;
   localparam logic [CP_W-1:0] PRINT_HIGH  = 21'h0007E;
   localparam logic [CP_W-1:0] CP_YEN      = 21'h0005C;
   localparam logic [CP_W-1:0] CP_OVERLINE = 21'h0007E;
   localparam logic [7:0]      PAD_BYTE    = 8'h20;

   localparam logic [1:0] STS_OK          = 2'd0;
   localparam logic [1:0] STS_MALFORMED   = 2'd1;
   localparam logic [1:0] STS_UNSUPPORTED = 2'd2;

   typedef enum logic {
      ST_IDLE,
      ST_BUSY
   } ctl_state_type;

   typedef enum logic [1:0] {
      ACT_NONE,
      ACT_FAIL,
      ACT_EMIT,
      ACT_PAD
   } act_type;

   typedef struct packed {
      logic load;
      logic step;
   } ctl_cmd_type;

   typedef struct packed {
      logic has_work;
      logic slot_free;
      logic end_step;
   } dp_status_type;

   // half-width code for katakana U+30A1 + idx; mark byte in the upper half
   function automatic logic [15:0] kana_lookup(input logic [6:0] idx);
      logic [15:0] v;
      case (idx)
         7'd0:  v = 16'h00A7;
         7'd1:  v = 16'h00B1;
         7'd2:  v = 16'h00A8;
         7'd3:  v = 16'h00B2;
         7'd4:  v = 16'h00A9;
         7'd5:  v = 16'h00B3;
         7'd6:  v = 16'h00AA;
         7'd7:  v = 16'h00B4;
         7'd8:  v = 16'h00AB;
         7'd9:  v = 16'h00B5;
         7'd10: v = 16'h00B6;
         7'd11: v = 16'hDEB6;
         7'd12: v = 16'h00B7;
         7'd13: v = 16'hDEB7;
         7'd14: v = 16'h00B8;
         7'd15: v = 16'hDEB8;
         7'd16: v = 16'h00B9;
         7'd17: v = 16'hDEB9;
         7'd18: v = 16'h00BA;
         7'd19: v = 16'hDEBA;
         7'd20: v = 16'h00BB;
         7'd21: v = 16'hDEBB;
         7'd22: v = 16'h00BC;
         7'd23: v = 16'hDEBC;
         7'd24: v = 16'h00BD;
         7'd25: v = 16'hDEBD;
         7'd26: v = 16'h00BE;
         7'd27: v = 16'hDEBE;
         7'd28: v = 16'h00BF;
         7'd29: v = 16'hDEBF;
         7'd30: v = 16'h00C0;
         7'd31: v = 16'hDEC0;
         7'd32: v = 16'h00C1;
         7'd33: v = 16'hDEC1;
         7'd34: v = 16'h00AF;
         7'd35: v = 16'h00C2;
         7'd36: v = 16'hDEC2;
         7'd37: v = 16'h00C3;
         7'd38: v = 16'hDEC3;
         7'd39: v = 16'h00C4;
         7'd40: v = 16'hDEC4;
         7'd41: v = 16'h00C5;
         7'd42: v = 16'h00C6;
         7'd43: v = 16'h00C7;
         7'd44: v = 16'h00C8;
         7'd45: v = 16'h00C9;
         7'd46: v = 16'h00CA;
         7'd47: v = 16'hDECA;
         7'd48: v = 16'hDFCA;
         7'd49: v = 16'h00CB;
         7'd50: v = 16'hDECB;
         7'd51: v = 16'hDFCB;
         7'd52: v = 16'h00CC;
         7'd53: v = 16'hDECC;
         7'd54: v = 16'hDFCC;
         7'd55: v = 16'h00CD;
         7'd56: v = 16'hDECD;
         7'd57: v = 16'hDFCD;
         7'd58: v = 16'h00CE;
         7'd59: v = 16'hDECE;
         7'd60: v = 16'hDFCE;
         7'd61: v = 16'h00CF;
         7'd62: v = 16'h00D0;
         7'd63: v = 16'h00D1;
         7'd64: v = 16'h00D2;
         7'd65: v = 16'h00D3;
         7'd66: v = 16'h00AC;
         7'd67: v = 16'h00D4;
         7'd68: v = 16'h00AD;
         7'd69: v = 16'h00D5;
         7'd70: v = 16'h00AE;
         7'd71: v = 16'h00D6;
         7'd72: v = 16'h00D7;
         7'd73: v = 16'h00D8;
         7'd74: v = 16'h00D9;
         7'd75: v = 16'h00DA;
         7'd76: v = 16'h00DB;
         7'd78: v = 16'h00DC;
         7'd81: v = 16'h00A6;
         7'd82: v = 16'h00DD;
         7'd83: v = 16'hDEB3;
         7'd86: v = 16'hDEDC;
         7'd89: v = 16'hDEA6;
         7'd90: v = 16'h00A5;
         7'd91: v = 16'h00B0;
         default: v = 16'h0000;
      endcase
      return v;
   endfunction

endpackage

@@ rtl/u8hk_ctrl.sv @@
module u8hk_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  u8hk_pkg::dp_status_type stat,
   output u8hk_pkg::ctl_cmd_type   cmd
);

   u8hk_pkg::ctl_state_type state_ff;
   u8hk_pkg::ctl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= u8hk_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd        = '0;
      case (state_ff)
         u8hk_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = u8hk_pkg::ST_BUSY;
            end
         end
         u8hk_pkg::ST_BUSY: begin
            cmd.step = stat.has_work && stat.slot_free;
            // words that give no result fall straight back to idle
            if (!stat.has_work || (cmd.step && stat.end_step)) begin
               state_in = u8hk_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = u8hk_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

@@ rtl/u8hk_datapath.sv @@
`include "assert_macros.svh"

module u8hk_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [7:0]              in_byte,
   input  logic                    in_first,
   input  u8hk_pkg::ctl_cmd_type   cmd,
   output u8hk_pkg::dp_status_type stat,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [15:0]             rsp_tdata,
   output logic [1:0]              rsp_tuser,
   output logic                    rsp_tlast
);

   // decoder state
   logic [1:0]                     cont_ff, cont_in;
   logic [u8hk_pkg::CP_W-1:0]      acc_ff, acc_in;
   logic [u8hk_pkg::POS_W-1:0]     pos_ff, pos_in;
   logic                           fin_ff, fin_in;

   // pending action of the word in flight
   u8hk_pkg::act_type              act_ff, act_in;
   logic [7:0]                     base_ff, base_in;
   logic [7:0]                     mark_ff, mark_in;
   logic [1:0]                     sts_ff, sts_in;
   logic                           phase_ff, phase_in;

   // output register
   logic                           ovalid_ff, ovalid_in;
   logic [7:0]                     obyte_ff, obyte_in;
   logic [u8hk_pkg::POS_W-1:0]     opos_ff, opos_in;
   logic [1:0]                     osts_ff, osts_in;
   logic                           olast_ff, olast_in;

   // decode of the incoming word
   logic [1:0]                     cont_eff;
   logic [u8hk_pkg::CP_W-1:0]      acc_eff;
   logic [u8hk_pkg::POS_W-1:0]     pos_eff;
   logic                           fin_eff;
   logic [1:0]                     dec_cont;
   logic [u8hk_pkg::CP_W-1:0]      dec_acc;
   logic                           dec_eval;
   u8hk_pkg::act_type              dec_act;
   logic [7:0]                     dec_base;
   logic [7:0]                     dec_mark;
   logic [1:0]                     dec_sts;
   logic [u8hk_pkg::CP_W-1:0]      kana_off;
   logic [15:0]                    kana_val;

   logic                           field_full;
   logic                           slot_free;
   logic                           end_step;

   assign slot_free  = !ovalid_ff || rsp_tready;
   assign field_full = ({1'b0, pos_ff} + 6'd1) >= 6'(u8hk_pkg::FIELD_LEN);

   assign kana_off = dec_acc - u8hk_pkg::KANA_FIRST;
   assign kana_val = u8hk_pkg::kana_lookup(kana_off[6:0]);

   always_comb begin
      // a first word starts from the cleared state
      cont_eff = in_first ? 2'd0 : cont_ff;
      acc_eff  = in_first ? '0 : acc_ff;
      pos_eff  = in_first ? '0 : pos_ff;
      fin_eff  = in_first ? 1'b0 : fin_ff;

      dec_cont = cont_eff;
      dec_acc  = acc_eff;
      dec_eval = 1'b0;
      dec_act  = u8hk_pkg::ACT_NONE;
      dec_base = '0;
      dec_mark = '0;
      dec_sts  = u8hk_pkg::STS_OK;

      if (fin_eff) begin
         dec_act = u8hk_pkg::ACT_NONE;
      end else if (cont_eff != 2'd0) begin
         if (in_byte[7:6] != 2'b10) begin
            dec_act  = u8hk_pkg::ACT_FAIL;
            dec_sts  = u8hk_pkg::STS_MALFORMED;
            dec_cont = 2'd0;
         end else begin
            dec_acc  = {acc_eff[u8hk_pkg::CP_W-7:0], in_byte[5:0]};
            dec_cont = cont_eff - 2'd1;
            dec_eval = (dec_cont == 2'd0);
         end
      end else if (!in_byte[7]) begin
         dec_acc  = {13'd0, in_byte};
         dec_eval = 1'b1;
      end else if (!in_byte[6]) begin
         dec_act = u8hk_pkg::ACT_FAIL;
         dec_sts = u8hk_pkg::STS_MALFORMED;
      end else if (!in_byte[5]) begin
         dec_acc  = {16'd0, in_byte[4:0]};
         dec_cont = 2'd1;
      end else if (!in_byte[4]) begin
         dec_acc  = {17'd0, in_byte[3:0]};
         dec_cont = 2'd2;
      end else if (!in_byte[3]) begin
         dec_acc  = {18'd0, in_byte[2:0]};
         dec_cont = 2'd3;
      end else begin
         dec_act = u8hk_pkg::ACT_FAIL;
         dec_sts = u8hk_pkg::STS_MALFORMED;
      end

      if (dec_eval) begin
         if (dec_acc == '0) begin
            dec_act = u8hk_pkg::ACT_PAD;
         end else if (dec_acc >= u8hk_pkg::PRINT_LOW && dec_acc <= u8hk_pkg::PRINT_HIGH) begin
            if (dec_acc == u8hk_pkg::CP_YEN || dec_acc == u8hk_pkg::CP_OVERLINE) begin
               dec_act = u8hk_pkg::ACT_FAIL;
               dec_sts = u8hk_pkg::STS_UNSUPPORTED;
            end else begin
               dec_act  = u8hk_pkg::ACT_EMIT;
               dec_base = dec_acc[7:0];
            end
         end else if (dec_acc >= u8hk_pkg::KANA_FIRST && dec_acc <= u8hk_pkg::KANA_LAST) begin
            if (kana_val == 16'h0000) begin
               dec_act = u8hk_pkg::ACT_FAIL;
               dec_sts = u8hk_pkg::STS_UNSUPPORTED;
            end else begin
               dec_act  = u8hk_pkg::ACT_EMIT;
               dec_base = kana_val[7:0];
               dec_mark = kana_val[15:8];
            end
         end else begin
            dec_act = u8hk_pkg::ACT_FAIL;
            dec_sts = u8hk_pkg::STS_UNSUPPORTED;
         end
      end
   end

   always_comb begin
      case (act_ff)
         u8hk_pkg::ACT_FAIL: end_step = 1'b1;
         u8hk_pkg::ACT_PAD:  end_step = field_full;
         u8hk_pkg::ACT_EMIT: end_step = field_full || phase_ff || (mark_ff == 8'h00);
         default:            end_step = 1'b1;
      endcase
   end

   assign stat = '{has_work:  (act_ff != u8hk_pkg::ACT_NONE),
                   slot_free: slot_free,
                   end_step:  end_step};

   always_comb begin
      cont_in   = cont_ff;
      acc_in    = acc_ff;
      pos_in    = pos_ff;
      fin_in    = fin_ff;
      act_in    = act_ff;
      base_in   = base_ff;
      mark_in   = mark_ff;
      sts_in    = sts_ff;
      phase_in  = phase_ff;
      ovalid_in = ovalid_ff && !rsp_tready;
      obyte_in  = obyte_ff;
      opos_in   = opos_ff;
      osts_in   = osts_ff;
      olast_in  = olast_ff;

      if (cmd.load) begin
         cont_in  = dec_cont;
         acc_in   = dec_acc;
         pos_in   = pos_eff;
         fin_in   = fin_eff || (dec_act == u8hk_pkg::ACT_FAIL);
         act_in   = dec_act;
         base_in  = dec_base;
         mark_in  = dec_mark;
         sts_in   = dec_sts;
         phase_in = 1'b0;
      end else if (cmd.step) begin
         ovalid_in = 1'b1;
         opos_in   = pos_ff;
         if (act_ff == u8hk_pkg::ACT_FAIL) begin
            obyte_in = 8'h00;
            osts_in  = sts_ff;
            olast_in = 1'b1;
         end else begin
            case (act_ff)
               u8hk_pkg::ACT_PAD:  obyte_in = u8hk_pkg::PAD_BYTE;
               u8hk_pkg::ACT_EMIT: obyte_in = phase_ff ? mark_ff : base_ff;
               default:            obyte_in = 8'h00;
            endcase
            osts_in  = u8hk_pkg::STS_OK;
            olast_in = field_full;
            if (field_full) begin
               fin_in = 1'b1;
            end else begin
               pos_in = pos_ff + 5'd1;
            end
            // a mark byte that would land past the field end is dropped
            if (act_ff == u8hk_pkg::ACT_EMIT && !phase_ff && mark_ff != 8'h00) begin
               phase_in = 1'b1;
            end
         end
         if (end_step) begin
            act_in = u8hk_pkg::ACT_NONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cont_ff   <= 2'd0;
         acc_ff    <= '0;
         pos_ff    <= '0;
         fin_ff    <= 1'b0;
         act_ff    <= u8hk_pkg::ACT_NONE;
         phase_ff  <= 1'b0;
         ovalid_ff <= 1'b0;
      end else begin
         cont_ff   <= cont_in;
         acc_ff    <= acc_in;
         pos_ff    <= pos_in;
         fin_ff    <= fin_in;
         act_ff    <= act_in;
         phase_ff  <= phase_in;
         ovalid_ff <= ovalid_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff  <= base_in;
      mark_ff  <= mark_in;
      sts_ff   <= sts_in;
      obyte_ff <= obyte_in;
      opos_ff  <= opos_in;
      osts_ff  <= osts_in;
      olast_ff <= olast_in;
   end

   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata  = {3'b000, opos_ff, obyte_ff};
   assign rsp_tuser  = osts_ff;
   assign rsp_tlast  = olast_ff;

   `ASSERT_NEVER(a_step_overwrites_output, cmd.step && !slot_free)
   `ASSERT_NEVER(a_load_while_busy, cmd.load && (act_ff != u8hk_pkg::ACT_NONE))
   `ASSERT_NEVER(a_pos_in_field, {1'b0, pos_ff} >= 6'(u8hk_pkg::FIELD_LEN))
   `ASSERT_CLK(a_error_is_last, (ovalid_ff && osts_ff != u8hk_pkg::STS_OK) |-> (olast_ff && obyte_ff == 8'h00))

endmodule

@@ rtl/utf8_to_halfwidth_katakana_field_core.sv @@
// each input word is first registered as a pending action, and its result words follow
// (0, 1, 2, or up to 20 of them); no new input word is taken until the last one is loaded
// the emission sequencer loads one result word per cycle into the output register; while that
// register waits on rsp_tready the sequencer and the input stall
// reset: synchronous, active high; clears the decoder state, pending work and the output valid

module utf8_to_halfwidth_katakana_field_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic        req_tuser,   // [0] first
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] out_byte, [12:8] out_pos, [15:13] zero
   output logic [1:0]  rsp_tuser,   // [1:0] status
   output logic        rsp_tlast    // last
);

   u8hk_pkg::ctl_cmd_type   cmd;
   u8hk_pkg::dp_status_type stat;

   u8hk_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   u8hk_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .in_byte    (req_tdata),
      .in_first   (req_tuser),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

@@ tb/utf8_to_halfwidth_katakana_field_core_tb.sv @@
module utf8_to_halfwidth_katakana_field_core_tb;

   localparam int RANDOM_ITEMS = 70;
   localparam int CALM_ITEMS   = 15;
   localparam int LONG_HOLD    = 120;
   localparam int TAIL_CYCLES  = 40;
   localparam int RUN_LIMIT    = 300000;
   localparam int MAX_REPORTS  = 40;

   typedef struct packed {
      logic [7:0]                 out_byte;
      logic [u8hk_pkg::POS_W-1:0] out_pos;
      logic [1:0]                 status;
      logic                       last;
   } field_word_type;

   typedef struct packed {
      logic [7:0]     in_byte;
      logic           first;
      logic           typed;
      field_word_type want;
   } stim_row_type;

   localparam field_word_type NO_WORD = '0;

   // half-width codes for U+30A1 onwards; a mark byte sits in the upper half
   localparam logic [15:0] HALFWIDTH_CODE [0:91] = '{
      16'h00A7, 16'h00B1, 16'h00A8, 16'h00B2, 16'h00A9, 16'h00B3, 16'h00AA, 16'h00B4,
      16'h00AB, 16'h00B5, 16'h00B6, 16'hDEB6, 16'h00B7, 16'hDEB7, 16'h00B8, 16'hDEB8,
      16'h00B9, 16'hDEB9, 16'h00BA, 16'hDEBA, 16'h00BB, 16'hDEBB, 16'h00BC, 16'hDEBC,
      16'h00BD, 16'hDEBD, 16'h00BE, 16'hDEBE, 16'h00BF, 16'hDEBF, 16'h00C0, 16'hDEC0,
      16'h00C1, 16'hDEC1, 16'h00AF, 16'h00C2, 16'hDEC2, 16'h00C3, 16'hDEC3, 16'h00C4,
      16'hDEC4, 16'h00C5, 16'h00C6, 16'h00C7, 16'h00C8, 16'h00C9, 16'h00CA, 16'hDECA,
      16'hDFCA, 16'h00CB, 16'hDECB, 16'hDFCB, 16'h00CC, 16'hDECC, 16'hDFCC, 16'h00CD,
      16'hDECD, 16'hDFCD, 16'h00CE, 16'hDECE, 16'hDFCE, 16'h00CF, 16'h00D0, 16'h00D1,
      16'h00D2, 16'h00D3, 16'h00AC, 16'h00D4, 16'h00AD, 16'h00D5, 16'h00AE, 16'h00D6,
      16'h00D7, 16'h00D8, 16'h00D9, 16'h00DA, 16'h00DB, 16'h0000, 16'h00DC, 16'h0000,
      16'h0000, 16'h00A6, 16'h00DD, 16'hDEB3, 16'h0000, 16'h0000, 16'hDEDC, 16'h0000,
      16'h0000, 16'hDEA6, 16'h00A5, 16'h00B0
   };

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [7:0] in_byte
   logic        req_tuser;   // [0] first
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;   // [7:0] out_byte, [12:8] out_pos, [15:13] zero
   logic [1:0]  rsp_tuser;   // [1:0] status
   logic        rsp_tlast;

   // title decoder state as the block should hold it
   logic [1:0]                 cont_left;
   logic [20:0]                cp_acc;
   logic [u8hk_pkg::POS_W-1:0] wr_pos;
   bit                         title_done;

   field_word_type expected_words [$];
   field_word_type step_words [$];
   bit             step_ignored;

   int mismatch_count = 0;
   int cycle_count    = 0;
   int random_items   = 0;
   bit title_start    = 1'b0;

   logic calm;
   logic long_hold_req;
   logic long_hold_done;
   logic hold_active;

   utf8_to_halfwidth_katakana_field_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= RUN_LIMIT) begin
         $display("** utf8_to_halfwidth_katakana_field_core: FAILED **");
         $finish;
      end
   end

   function automatic void emit_field_byte(input logic [7:0] value);
      if (int'(wr_pos) + 1 >= u8hk_pkg::FIELD_LEN) begin
         title_done = 1'b1;
         step_words.push_back('{value, wr_pos, u8hk_pkg::STS_OK, 1'b1});
      end else begin
         step_words.push_back('{value, wr_pos, u8hk_pkg::STS_OK, 1'b0});
         wr_pos = wr_pos + 1'b1;
      end
   endfunction

   function automatic void end_title(input logic [1:0] status);
      title_done = 1'b1;
      cont_left  = '0;
      step_words.push_back('{8'h00, wr_pos, status, 1'b1});
   endfunction

   // works out the field words that one input byte yields
   function automatic void predict_title_step(input logic [7:0] in_byte, input logic first);
      logic [15:0] code;
      step_words.delete();
      if (first) begin
         cont_left  = '0;
         cp_acc     = '0;
         wr_pos     = '0;
         title_done = 1'b0;
      end
      step_ignored = title_done;
      if (title_done)
         return;

      if (cont_left != 0) begin
         if (in_byte[7:6] != 2'b10) begin
            end_title(u8hk_pkg::STS_MALFORMED);
            return;
         end
         cp_acc    = {cp_acc[14:0], in_byte[5:0]};
         cont_left = cont_left - 1'b1;
         if (cont_left != 0)
            return;
      end else if (!in_byte[7]) begin
         cp_acc = {13'd0, in_byte};
      end else if (!in_byte[6]) begin
         end_title(u8hk_pkg::STS_MALFORMED);
         return;
      end else if (!in_byte[5]) begin
         cp_acc    = {16'd0, in_byte[4:0]};
         cont_left = 2'd1;
         return;
      end else if (!in_byte[4]) begin
         cp_acc    = {17'd0, in_byte[3:0]};
         cont_left = 2'd2;
         return;
      end else if (!in_byte[3]) begin
         cp_acc    = {18'd0, in_byte[2:0]};
         cont_left = 2'd3;
         return;
      end else begin
         end_title(u8hk_pkg::STS_MALFORMED);
         return;
      end

      if (cp_acc == 0) begin
         while (!title_done)
            emit_field_byte(u8hk_pkg::PAD_BYTE);
      end else if (cp_acc >= u8hk_pkg::PRINT_LOW && cp_acc <= u8hk_pkg::PRINT_HIGH) begin
         if (cp_acc == u8hk_pkg::CP_YEN || cp_acc == u8hk_pkg::CP_OVERLINE)
            end_title(u8hk_pkg::STS_UNSUPPORTED);
         else
            emit_field_byte(cp_acc[7:0]);
      end else if (cp_acc >= u8hk_pkg::KANA_FIRST && cp_acc <= u8hk_pkg::KANA_LAST) begin
         code = HALFWIDTH_CODE[int'(cp_acc - u8hk_pkg::KANA_FIRST)];
         if (code == 0) begin
            end_title(u8hk_pkg::STS_UNSUPPORTED);
         end else begin
            emit_field_byte(code[7:0]);
            // mark byte dropped when the base byte filled the field
            if (!title_done && code[15:8] != 0)
               emit_field_byte(code[15:8]);
         end
      end else begin
         end_title(u8hk_pkg::STS_UNSUPPORTED);
      end
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("mismatch at cycle %0d: %s", cycle_count, what);
   endtask

   always @(posedge clock) begin : rsp_check
      field_word_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         if (expected_words.size() == 0) begin
            report_mismatch($sformatf("word %h status %0d last %b with nothing expected",
                                      rsp_tdata, rsp_tuser, rsp_tlast));
         end else begin
            want = expected_words.pop_front();
            if (rsp_tdata[7:0] !== want.out_byte)
               report_mismatch($sformatf("out_byte %h, expected %h at pos %0d",
                                         rsp_tdata[7:0], want.out_byte, want.out_pos));
            if (rsp_tdata[12:8] !== want.out_pos)
               report_mismatch($sformatf("out_pos %0d, expected %0d",
                                         rsp_tdata[12:8], want.out_pos));
            if (rsp_tuser !== want.status)
               report_mismatch($sformatf("status %0d, expected %0d at pos %0d",
                                         rsp_tuser, want.status, want.out_pos));
            if (rsp_tlast !== want.last)
               report_mismatch($sformatf("last %b, expected %b at pos %0d",
                                         rsp_tlast, want.last, want.out_pos));
         end
      end
   end

   // result side: random stalls, one long hold-off on request
   initial begin : rsp_side
      int span;
      rsp_tready     <= 1'b0;
      long_hold_done <= 1'b0;
      hold_active    <= 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_req === 1'b1 && !long_hold_done) begin
            rsp_tready  <= 1'b0;
            hold_active <= 1'b1;
            repeat (LONG_HOLD - 1) @(posedge clock);
            long_hold_done <= 1'b1;
            hold_active    <= 1'b0;
         end else if (calm !== 1'b1 && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            span = $urandom_range(1, 17);
            repeat (span - 1) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            span = $urandom_range(1, 25);
            repeat (span - 1) @(posedge clock);
         end
      end
   end

   task automatic send_word(input logic [7:0] in_byte, input logic first,
                            input bit typed, input field_word_type want);
      int gap;
      if (!calm && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 17);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= in_byte;
      req_tuser  <= first;
      do @(posedge clock); while (req_tready !== 1'b1);
      predict_title_step(in_byte, first);
      if (typed)
         expected_words.push_back(want);
      else
         foreach (step_words[i])
            expected_words.push_back(step_words[i]);
      if (!step_ignored)
         random_items++;
   endtask

   // first is set on the opening byte of a title and now and then at random
   task automatic send_byte(input logic [7:0] in_byte);
      logic first;
      first       = title_start || ($urandom_range(0, 60) == 0);
      title_start = 1'b0;
      send_word(in_byte, first, 1'b0, NO_WORD);
   endtask

   task automatic send_code(input logic [20:0] cp, input int len);
      case (len)
         1: send_byte({1'b0, cp[6:0]});
         2: begin
            send_byte({3'b110, cp[10:6]});
            send_byte({2'b10, cp[5:0]});
         end
         3: begin
            send_byte({4'b1110, cp[15:12]});
            send_byte({2'b10, cp[11:6]});
            send_byte({2'b10, cp[5:0]});
         end
         default: begin
            send_byte({5'b11110, cp[20:18]});
            send_byte({2'b10, cp[17:12]});
            send_byte({2'b10, cp[11:6]});
            send_byte({2'b10, cp[5:0]});
         end
      endcase
   endtask

   function automatic logic [20:0] voiced_kana();
      return u8hk_pkg::KANA_FIRST + 21'd11 + 21'(2 * $urandom_range(0, 11));
   endfunction

   task automatic send_char();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: send_code(21'($urandom_range(8'h20, 8'h7E)), 1);
         4, 5, 6:    send_code(21'($urandom_range(u8hk_pkg::KANA_FIRST,
                                                  u8hk_pkg::KANA_LAST)), 3);
         7:          send_code(voiced_kana(), 3);
         8: begin
            case ($urandom_range(0, 4))
               0: send_code(21'($urandom_range(1, 31)), 1);
               1: send_code(21'h7F, 1);
               2: send_code(21'($urandom_range(21'h80, 21'h7FF)), 2);
               3: send_code(21'($urandom_range(21'h800, 21'hFFFF)), 3);
               default: send_code(21'($urandom_range(21'h10000, 21'h1FFFFF)), 4);
            endcase
         end
         // overlong forms, the zero one included
         default: send_code(21'($urandom_range(0, 127)), $urandom_range(2, 4));
      endcase
   endtask

   task automatic send_random_title();
      int kind;
      int count;
      kind        = $urandom_range(0, 9);
      title_start = 1'b1;
      if (kind < 7) begin
         count = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 8);
         repeat (count) send_char();
         case ($urandom_range(0, 3))
            0, 1: send_byte(8'h00);
            2:    send_code(21'd0, $urandom_range(2, 4));
            default: ;
         endcase
      end else if (kind < 9) begin
         repeat ($urandom_range(0, 3)) send_char();
         case ($urandom_range(0, 2))
            0: begin
               send_byte(8'($urandom_range(8'hC2, 8'hF7)));
               send_byte($urandom_range(0, 1) ? 8'($urandom_range(0, 8'h7F))
                                              : 8'($urandom_range(8'hC0, 8'hFF)));
            end
            1: send_byte(8'($urandom_range(8'h80, 8'hBF)));
            default: send_byte(8'($urandom_range(8'hF8, 8'hFF)));
         endcase
      end else begin
         title_start = 1'($urandom_range(0, 1));
         repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
      end
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_words.size() != 0);
   endtask

   initial begin : stimulus
      stim_row_type directed_rows [0:24];
      directed_rows = '{
         '{8'hFF, 1'b0, 1'b1, '{8'h00, 5'd0, u8hk_pkg::STS_MALFORMED, 1'b1}}, // before any first
         '{8'h41, 1'b0, 1'b0, NO_WORD},                             // ignored once finished
         '{8'h41, 1'b1, 1'b1, '{8'h41, 5'd0, u8hk_pkg::STS_OK, 1'b0}},
         '{8'h20, 1'b0, 1'b1, '{8'h20, 5'd1, u8hk_pkg::STS_OK, 1'b0}},
         '{8'h5C, 1'b0, 1'b1, '{8'h00, 5'd2, u8hk_pkg::STS_UNSUPPORTED, 1'b1}},
         '{8'hE3, 1'b1, 1'b0, NO_WORD},                             // first katakana
         '{8'h82, 1'b0, 1'b0, NO_WORD},
         '{8'hA1, 1'b0, 1'b0, NO_WORD},
         '{8'hE3, 1'b0, 1'b0, NO_WORD},                             // semi-voiced
         '{8'h83, 1'b0, 1'b0, NO_WORD},
         '{8'h91, 1'b0, 1'b0, NO_WORD},
         '{8'hE3, 1'b0, 1'b0, NO_WORD},                             // voiced
         '{8'h82, 1'b0, 1'b0, NO_WORD},
         '{8'hAC, 1'b0, 1'b0, NO_WORD},
         '{8'hC0, 1'b0, 1'b0, NO_WORD},                             // overlong nul pads
         '{8'h80, 1'b0, 1'b0, NO_WORD},
         '{8'h80, 1'b1, 1'b1, '{8'h00, 5'd0, u8hk_pkg::STS_MALFORMED, 1'b1}},
         '{8'hE3, 1'b1, 1'b0, NO_WORD},
         '{8'h00, 1'b0, 1'b1, '{8'h00, 5'd0, u8hk_pkg::STS_MALFORMED, 1'b1}}, // nul as continuation
         '{8'hE3, 1'b1, 1'b0, NO_WORD},                             // katakana with no code
         '{8'h83, 1'b0, 1'b0, NO_WORD},
         '{8'hB0, 1'b0, 1'b0, NO_WORD},
         '{8'h7E, 1'b1, 1'b1, '{8'h00, 5'd0, u8hk_pkg::STS_UNSUPPORTED, 1'b1}},
         '{8'h01, 1'b1, 1'b1, '{8'h00, 5'd0, u8hk_pkg::STS_UNSUPPORTED, 1'b1}},
         '{8'h00, 1'b1, 1'b0, NO_WORD}                              // whole field of spaces
      };

      reset         <= 1'b1;
      req_tvalid    <= 1'b0;
      req_tdata     <= '0;
      req_tuser     <= 1'b0;
      calm          <= 1'b0;
      long_hold_req <= 1'b0;
      cont_left      = '0;
      cp_acc         = '0;
      wr_pos         = '0;
      title_done     = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_word(directed_rows[i].in_byte, directed_rows[i].first,
                   directed_rows[i].typed, directed_rows[i].want);
      drain_results();
      random_items = 0;

      // field fills on the base byte of a voiced kana, then stray bytes
      title_start = 1'b1;
      repeat (19) send_byte(8'($urandom_range(8'h41, 8'h5A)));
      send_code(voiced_kana(), 3);
      repeat (3) send_byte(8'($urandom_range(0, 255)));

      // results held back while words keep coming
      req_tvalid    <= 1'b0;
      long_hold_req <= 1'b1;
      do @(posedge clock); while (hold_active !== 1'b1);
      title_start = 1'b1;
      repeat (8) send_code(voiced_kana(), 3);
      send_byte(8'h00);
      drain_results();

      while (random_items < RANDOM_ITEMS) begin
         if (random_items >= RANDOM_ITEMS - CALM_ITEMS)
            calm <= 1'b1;
         send_random_title();
      end

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("** utf8_to_halfwidth_katakana_field_core: PASSED **");
      else
         $display("** utf8_to_halfwidth_katakana_field_core: FAILED **");
      $finish;
   end

endmodule
